// File: sv/tabx_pkg.sv
package tabx_pkg;

    localparam int MAX_STOPS = 8;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_BLANK   = 8'd32;

    localparam logic [4:0] RESET_WIDTH = 5'd4;
    localparam logic [4:0] WIDTH_CAP   = 5'd16;
    localparam logic [5:0] RUN_CAP     = 6'd63;

    localparam logic [1:0] CFG_DEFAULT_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_STOP_COUNT     = 2'd1;
    localparam logic [1:0] CFG_STOP_POSITIONS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_char;
        logic div_start;
        logic div_step;
        logic run_load;
        logic emit_blank;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tab;
        logic out_free;
        logic div_done;
        logic run_last;
    } dp_status_t;

endpackage

// File: sv/tab_expander.sv
// tab expander: text bytes in, bytes out with each tab turned into blanks
// up to the next tab stop (first listed stop past the column, otherwise the
// next multiple of default_width). newline clears the column.
// input channel: in_valid / in_stall / in_char. output channel: out_valid /
// out_stall / out_char / last, where last marks the final item of a byte.
// configuration: cfg_we / cfg_index / cfg_data, to be written only while idle
// (the block does not enforce this); index 0 default_width, 1 stop_count, 2 stop_positions.
// ordinary bytes: one item per cycle while the output register is free, the
// result in that register the cycle after acceptance. a tab: taken while idle,
// then one remainder step per column bit in the bit-serial remainder unit, a
// state to pick the run, then one blank per cycle while the register is free;
// the next byte is taken once the last blank is loaded into that register.
// when out_stall is high the output register holds its item and in_stall
// rises until the register frees up.
// reset clears the column, empties the output register and loads the
// registers with width 4, no stop list.
module tab_expander #(
    parameter int COLUMN_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last
);
    import tabx_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tabx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tabx_datapath #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_char   (in_char),
        .out_char  (out_char),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: sv/tabx_ctrl.sv
module tabx_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tabx_pkg::dp_status_t  status,
    output tabx_pkg::dp_cmd_t     cmd
);
    import tabx_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.out_free && status.is_tab)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !status.out_free;
                if (in_valid && status.out_free)
                begin
                    if (status.is_tab)
                    begin
                        cmd.div_start = 1'b1;
                    end
                    else
                    begin
                        cmd.load_char = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_RUN:
            begin
                cmd.run_load = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_blank = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/tabx_datapath.sv
module tabx_datapath #(
    parameter int COLUMN_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic [7:0]            in_char,
    output logic [7:0]            out_char,
    output logic                  last,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  tabx_pkg::dp_cmd_t     cmd,
    output tabx_pkg::dp_status_t  status
);
    import tabx_pkg::*;

    localparam int CNT_W = $clog2(COLUMN_BITS);
    localparam int CMP_W = (COLUMN_BITS > 8) ? COLUMN_BITS : 8;

    logic [4:0]             default_width_reg;
    logic [3:0]             stop_count_reg;
    logic [63:0]            stop_positions_reg;
    logic [COLUMN_BITS-1:0] column_reg;
    logic [COLUMN_BITS-1:0] column_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CNT_W-1:0]       div_cnt_reg;
    logic [CNT_W-1:0]       div_cnt_next;

    logic [7:0]             out_char_reg;
    logic                   last_reg;
    logic [3:0]             div_rem_reg;
    logic [3:0]             div_rem_next;
    logic [COLUMN_BITS-1:0] div_shift_reg;
    logic [5:0]             run_total_reg;
    logic [5:0]             remain_reg;

    logic                   out_free;
    logic [4:0]             width_eff;
    logic [4:0]             div_trial;
    logic [3:0]             stop_lim;
    logic                   hit;
    logic [7:0]             hit_stop;
    logic [CMP_W-1:0]       col_ext;
    logic [CMP_W-1:0]       hit_diff;
    logic [5:0]             run_calc;
    logic [COLUMN_BITS:0]   sum_one;
    logic [COLUMN_BITS:0]   sum_run;

    assign out_free = !out_valid_reg || !out_stall;

    // zero width acts as 1, anything above the cap acts as the cap
    always_comb
    begin
        if (default_width_reg == 5'd0)
        begin
            width_eff = 5'd1;
        end
        else if (default_width_reg > WIDTH_CAP)
        begin
            width_eff = WIDTH_CAP;
        end
        else
        begin
            width_eff = default_width_reg;
        end
    end

    // one restoring remainder step per cycle, msb of column first
    always_comb
    begin
        div_trial = {div_rem_reg, div_shift_reg[COLUMN_BITS-1]};
        if (div_trial >= width_eff)
        begin
            div_rem_next = 4'(div_trial - width_eff);
        end
        else
        begin
            div_rem_next = div_trial[3:0];
        end
    end

    assign stop_lim = (stop_count_reg > 4'(MAX_STOPS)) ? 4'(MAX_STOPS) : stop_count_reg;
    assign col_ext  = CMP_W'(column_reg);

    // first listed stop beyond the column wins
    always_comb
    begin
        hit      = 1'b0;
        hit_stop = '0;
        for (int i = MAX_STOPS - 1; i >= 0; i--)
        begin
            if ((4'(i) < stop_lim) && (CMP_W'(stop_positions_reg[8*i +: 8]) > col_ext))
            begin
                hit      = 1'b1;
                hit_stop = stop_positions_reg[8*i +: 8];
            end
        end
    end

    always_comb
    begin
        hit_diff = CMP_W'(hit_stop) - col_ext;
        if (hit)
        begin
            run_calc = (hit_diff > CMP_W'(RUN_CAP)) ? RUN_CAP : hit_diff[5:0];
        end
        else
        begin
            run_calc = 6'(width_eff - {1'b0, div_rem_reg});
        end
    end

    assign sum_one = {1'b0, column_reg} + (COLUMN_BITS+1)'(1);
    assign sum_run = {1'b0, column_reg} + (COLUMN_BITS+1)'(run_total_reg);

    always_comb
    begin
        column_next = column_reg;
        if (cmd.load_char)
        begin
            if (in_char == CH_NEWLINE)
            begin
                column_next = '0;
            end
            else
            begin
                column_next = sum_one[COLUMN_BITS] ? '1 : sum_one[COLUMN_BITS-1:0];
            end
        end
        else if (cmd.emit_blank && (remain_reg == 6'd1))
        begin
            column_next = sum_run[COLUMN_BITS] ? '1 : sum_run[COLUMN_BITS-1:0];
        end
    end

    always_comb
    begin
        if (cmd.load_char || cmd.emit_blank)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start)
        begin
            div_cnt_next = CNT_W'(COLUMN_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_width_reg  <= RESET_WIDTH;
            stop_count_reg     <= '0;
            stop_positions_reg <= '0;
            column_reg         <= '0;
            out_valid_reg      <= 1'b0;
            div_cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEFAULT_WIDTH:  default_width_reg  <= cfg_data[4:0];
                    CFG_STOP_COUNT:     stop_count_reg     <= cfg_data[3:0];
                    CFG_STOP_POSITIONS: stop_positions_reg <= cfg_data;
                    default:            stop_count_reg     <= stop_count_reg;
                endcase
            end
            column_reg    <= column_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            out_char_reg <= in_char;
            last_reg     <= 1'b1;
        end
        else if (cmd.emit_blank)
        begin
            out_char_reg <= CH_BLANK;
            last_reg     <= (remain_reg == 6'd1);
        end
        if (cmd.div_start)
        begin
            div_rem_reg   <= '0;
            div_shift_reg <= column_reg;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg   <= div_rem_next;
            div_shift_reg <= {div_shift_reg[COLUMN_BITS-2:0], 1'b0};
        end
        if (cmd.run_load)
        begin
            run_total_reg <= run_calc;
            remain_reg    <= run_calc;
        end
        else if (cmd.emit_blank)
        begin
            remain_reg <= remain_reg - 6'd1;
        end
    end

    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

    assign status.is_tab   = (in_char == CH_TAB);
    assign status.out_free = out_free;
    assign status.div_done = (div_cnt_reg == '0);
    assign status.run_last = (remain_reg == 6'd1);

endmodule

// File: tb/sv/tab_expander_tb.sv
`timescale 1ns / 1ps

module tab_expander_tb;

    import tabx_pkg::*;

    localparam int COL_BITS       = 10;
    localparam int COL_MAX        = (1 << COL_BITS) - 1;
    localparam int DRAIN_CYCLES   = COL_BITS + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 40;
    localparam int LONG_ITEMS     = 90;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } out_byte_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_DEFAULT_WIDTH;
    logic [63:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_char   = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_char;
    logic        last;

    // tab stop setup as the block should hold it
    logic [4:0]  width_cfg = RESET_WIDTH;
    logic [3:0]  count_cfg = '0;
    logic [63:0] stops_cfg = '0;
    int          column    = 0;

    out_byte_t   pending_out[$];

    int mismatches    = 0;
    int bytes_sent    = 0;
    int tabs_sent     = 0;
    int bytes_checked = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    int hold          = 0;
    bit calm          = 1'b0;

    always #1 clk = ~clk;

    tab_expander #(
        .COLUMN_BITS(COL_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // blanks from col to the next tab stop
    function automatic int blank_run(input int col);
        int n;
        int i;
        int s;
        int w;
        n = (count_cfg > MAX_STOPS) ? MAX_STOPS : count_cfg;
        for (i = 0; i < n; i++) begin
            s = int'(stops_cfg[8*i +: 8]);
            if (s > col)
                return (s - col > int'(RUN_CAP)) ? int'(RUN_CAP) : s - col;
        end
        w = (width_cfg == 0) ? 1 : (width_cfg > WIDTH_CAP) ? int'(WIDTH_CAP) : width_cfg;
        return w - (col % w);
    endfunction

    function void expand_char(input logic [7:0] c);
        int run;
        int k;
        if (c == CH_TAB) begin
            run = blank_run(column);
            for (k = 0; k < run; k++)
                pending_out.push_back(out_byte_t'{ch: CH_BLANK, is_final: (k == run - 1)});
            column = (column + run > COL_MAX) ? COL_MAX : column + run;
        end
        else begin
            pending_out.push_back(out_byte_t'{ch: c, is_final: 1'b1});
            if (c == CH_NEWLINE)
                column = 0;
            else
                column = (column + 1 > COL_MAX) ? COL_MAX : column + 1;
        end
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CH_TAB;
        if (r < 38)
            return CH_NEWLINE;
        return 8'($urandom_range(0, 255));
    endfunction

    // strictly ascending lists, steps small enough that a few pass column 63
    function automatic logic [63:0] ascending_stops();
        logic [63:0] v;
        int          s;
        int          i;
        s = 0;
        for (i = 0; i < 8; i++) begin
            s = s + $urandom_range(1, 12);
            v[8*i +: 8] = 8'(s);
        end
        return v;
    endfunction

    task send_char(input logic [7:0] c);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        do
            @(posedge clk);
        while (in_stall);
        expand_char(c);
        bytes_sent++;
        if (c == CH_TAB)
            tabs_sent++;
    endtask

    task settle();
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // upper data bits are random, the block should ignore them
    task load_setup(input logic [4:0] w, input logic [3:0] n, input logic [63:0] stops);
        logic [63:0] d;
        cfg_we    <= 1'b1;
        d         = {$urandom(), $urandom()};
        d[4:0]    = w;
        cfg_index <= CFG_DEFAULT_WIDTH;
        cfg_data  <= d;
        @(posedge clk);
        d         = {$urandom(), $urandom()};
        d[3:0]    = n;
        cfg_index <= CFG_STOP_COUNT;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= CFG_STOP_POSITIONS;
        cfg_data  <= stops;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_cfg = w;
        count_cfg = n;
        stops_cfg = stops;
    endtask

    task test_default_stops();
        send_char(CH_TAB);
        send_char(8'h61);
        send_char(CH_TAB);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_TAB);
        send_char(8'h55);
        send_char(8'hAA);
        send_char(CH_NEWLINE);
        send_char(CH_TAB);
        settle();
    endtask

    // zero width acts as width 1 once the list runs out
    task test_listed_stops();
        load_setup(5'd0, 4'd3, 64'h0000_0000_0028_0C05);
        send_char(CH_TAB);
        send_char(CH_TAB);
        send_char(8'h78);
        send_char(CH_TAB);
        send_char(CH_TAB);
        send_char(CH_NEWLINE);
        settle();
    endtask

    // oversized width and count, unordered list, entries past the blank cap
    task test_odd_lists();
        load_setup(5'd31, 4'd15, 64'h00FF_0001_3F0A_03C8);
        repeat (5) send_char(CH_TAB);
        send_char(8'h71);
        send_char(CH_NEWLINE);
        send_char(CH_TAB);
        send_char(CH_TAB);
        settle();
    endtask

    task test_random_text();
        int          p;
        int          i;
        logic [4:0]  w;
        logic [3:0]  n;
        logic [63:0] stops;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin w = 5'd1;  n = 4'd0;  end
                1: begin w = 5'd16; n = 4'd8;  end
                2: begin w = 5'd0;  n = 4'(MAX_STOPS); end
                3: begin w = 5'd31; n = 4'd15; end
                default: begin
                    w = 5'($urandom_range(0, 31));
                    n = 4'($urandom_range(0, 15));
                end
            endcase
            stops = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : ascending_stops();
            load_setup(w, n, stops);
            calm = (p == 4);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_char(random_char());
            settle();
        end
        calm = 1'b0;
    endtask

    // long line without newline: drives the column into saturation
    task test_long_lines();
        int i;
        load_setup(5'd16, 4'd1, {$urandom(), 24'($urandom_range(0, 255)), 8'hFF});
        for (i = 0; i < LONG_ITEMS; i++)
            send_char(($urandom_range(0, 6) == 0) ? 8'($urandom_range(33, 126)) : CH_TAB);
        send_char(8'h7E);
        send_char(CH_TAB);
        send_char(CH_NEWLINE);
        send_char(CH_TAB);
        settle();
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_out.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item out_char=%02h last=%0b",
                         $time, out_char, last);
            end
            else begin
                out_byte_t want;
                want = pending_out.pop_front();
                bytes_checked++;
                if (out_char !== want.ch) begin
                    mismatches++;
                    $display("%0t: out_char expected %02h actual %02h",
                             $time, want.ch, out_char);
                end
                if (last !== want.is_final) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.is_final, last);
                end
            end
            hold = pause_len();
            out_stall  <= (hold > 0);
            stall_left = (hold > 0) ? hold - 1 : 0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("[tab_expander] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_stops();
        test_listed_stops();
        test_odd_lists();
        test_random_text();
        test_long_lines();
        $display("sent %0d bytes (%0d tabs), checked %0d output bytes",
                 bytes_sent, tabs_sent, bytes_checked);
        $display("covered default and listed stops, odd setups and column saturation");
        if (mismatches == 0)
            $display("[tab_expander] OK");
        else
            $display("[tab_expander] ERROR");
        $finish;
    end

endmodule

// File: tab_expander.f
sv/tabx_pkg.sv
sv/tabx_ctrl.sv
sv/tabx_datapath.sv
sv/tab_expander.sv
tb/sv/tab_expander_tb.sv
